### hdl/ppmq_pkg.sv
package ppmq_pkg;

  localparam int DEPTH_DEFAULT  = 2048;
  localparam int THR_W          = 12;
  localparam int INIT_THRESHOLD = 1024;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [31:0] source;
    logic [31:0] session;
    logic [63:0] handle;
    logic [31:0] size;
  } msg_t;

endpackage

### hdl/ping_pong_message_queue_top.sv
// Channel   Handshake                 Payload
// in        in_valid / in_stall       operation, source_id, session_id, message_handle,
//                                     payload_size
// out       out_valid / out_stall     pop_valid, push_dropped, overload_seen, overload_fill,
//                                     source_out, session_out, handle_out, size_out
// cfg       cfg_we                    cfg_wdata (initial threshold)
//
// One item per cycle while in_stall is low; each result appears in the cycle after its item is accepted.
// Latency is set by the single registered read port of the message memory.
// rst clears bank pointers, fills, overload marks and the bank select; the message
// memory is not cleared. in_stall is high while a result is held by out_stall.
module ping_pong_message_queue_top #(
  parameter int DEPTH = ppmq_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ppmq_pkg::THR_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic signed [31:0]        source_id,
  input  logic signed [31:0]        session_id,
  input  logic [63:0]               message_handle,
  input  logic [31:0]               payload_size,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      pop_valid,
  output logic                      push_dropped,
  output logic                      overload_seen,
  output logic [ppmq_pkg::THR_W-1:0] overload_fill,
  output logic signed [31:0]        source_out,
  output logic signed [31:0]        session_out,
  output logic [63:0]               handle_out,
  output logic [31:0]               size_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW + 1;
  localparam int TW = (CW > ppmq_pkg::THR_W) ? CW : ppmq_pkg::THR_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

  function automatic logic [CW-1:0] clamp(input logic [ppmq_pkg::THR_W-1:0] v);
    logic [CW-1:0] res;
    if (v == '0) begin
      res = CW'(1);
    end else if (TW'(v) > TW'(DEPTH)) begin
      res = DEPTH_C;
    end else begin
      res = CW'(v);
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] dbl(input logic [CW-1:0] t);
    logic [PW-1:0] d;
    d = {t, 1'b0};
    return (d > PW'(DEPTH)) ? DEPTH_C : d[CW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] h);
    return (h == LAST_C) ? '0 : h + AW'(1);
  endfunction

  // control state
  logic [AW-1:0] head [2];
  logic [CW-1:0] fill [2];
  logic [CW-1:0] thr  [2];
  logic          ovl  [2];
  logic          read_bank;

  logic [AW-1:0] head_next [2];
  logic [CW-1:0] fill_next [2];
  logic [CW-1:0] thr_next  [2];
  logic          ovl_next  [2];
  logic          read_bank_next;

  // message memory, bank in the top address bit
  ppmq_pkg::msg_t mem [2**(AW+1)];
  ppmq_pkg::msg_t rd_data;
  logic           mem_we;
  logic [AW:0]    wr_addr;
  logic           rd_en;
  logic [AW:0]    rd_addr;

  // result register
  logic                       res_pop;
  logic                       res_drop;
  logic                       res_ovs;
  logic [ppmq_pkg::THR_W-1:0] res_ovf;
  logic                       res_pop_next;
  logic                       res_drop_next;
  logic                       res_ovs_next;
  logic [ppmq_pkg::THR_W-1:0] res_ovf_next;

  logic          accept;
  logic          wb;
  logic [AW-1:0] w_head, r_head, o_head;
  logic [CW-1:0] w_fill, r_fill, o_fill, w_thr, nf;
  logic          r_ovl;
  logic [PW-1:0] pos_sum, pos;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign wb     = ~read_bank;
  assign r_head = read_bank ? head[1] : head[0];
  assign r_fill = read_bank ? fill[1] : fill[0];
  assign r_ovl  = read_bank ? ovl[1]  : ovl[0];
  assign o_head = read_bank ? head[0] : head[1];
  assign o_fill = read_bank ? fill[0] : fill[1];
  assign w_head = o_head;
  assign w_fill = o_fill;
  assign w_thr  = read_bank ? thr[0] : thr[1];
  assign nf     = w_fill + CW'(1);

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      head_next[b] = head[b];
      fill_next[b] = fill[b];
      thr_next[b]  = thr[b];
      ovl_next[b]  = ovl[b];
    end
    read_bank_next = read_bank;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = {read_bank, r_head};
    res_pop_next  = 1'b0;
    res_drop_next = 1'b0;
    res_ovs_next  = 1'b0;
    res_ovf_next  = '0;

    pos_sum = PW'(w_head) + PW'(w_fill);
    pos     = (pos_sum >= PW'(DEPTH)) ? pos_sum - PW'(DEPTH) : pos_sum;
    wr_addr = {wb, pos[AW-1:0]};

    if (accept) begin
      if (operation == ppmq_pkg::OP_PUSH) begin
        if (w_fill == DEPTH_C) begin
          res_drop_next = 1'b1;
        end else begin
          mem_we        = 1'b1;
          fill_next[wb] = nf;
          if (nf >= w_thr) begin
            thr_next[wb] = dbl(w_thr);
            ovl_next[wb] = 1'b1;
          end
        end
      end else begin
        if (r_ovl) begin
          ovl_next[read_bank] = 1'b0;
          res_ovs_next        = 1'b1;
          res_ovf_next        = ppmq_pkg::THR_W'(r_fill);
        end
        if (r_fill != '0) begin
          rd_en                = 1'b1;
          res_pop_next         = 1'b1;
          head_next[read_bank] = inc(r_head);
          fill_next[read_bank] = r_fill - CW'(1);
        end else begin
          // reader bank empty: swap and try the other one
          read_bank_next = wb;
          rd_addr        = {wb, o_head};
          if (o_fill != '0) begin
            rd_en         = 1'b1;
            res_pop_next  = 1'b1;
            head_next[wb] = inc(o_head);
            fill_next[wb] = o_fill - CW'(1);
          end
        end
      end
    end

    if (cfg_we) begin
      thr_next[0] = clamp(cfg_wdata);
      thr_next[1] = clamp(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < 2; b++) begin
        head[b] <= '0;
        fill[b] <= '0;
        thr[b]  <= clamp(ppmq_pkg::THR_W'(ppmq_pkg::INIT_THRESHOLD));
        ovl[b]  <= 1'b0;
      end
      read_bank <= 1'b0;
    end else begin
      for (int b = 0; b < 2; b++) begin
        head[b] <= head_next[b];
        fill[b] <= fill_next[b];
        thr[b]  <= thr_next[b];
        ovl[b]  <= ovl_next[b];
      end
      read_bank <= read_bank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{source: source_id, session: session_id,
                        handle: message_handle, size: payload_size};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_pop  <= res_pop_next;
      res_drop <= res_drop_next;
      res_ovs  <= res_ovs_next;
      res_ovf  <= res_ovf_next;
    end
  end

  assign pop_valid     = res_pop;
  assign push_dropped  = res_drop;
  assign overload_seen = res_ovs;
  assign overload_fill = res_ovf;
  assign source_out    = res_pop ? $signed(rd_data.source)  : '0;
  assign session_out   = res_pop ? $signed(rd_data.session) : '0;
  assign handle_out    = res_pop ? rd_data.handle : '0;
  assign size_out      = res_pop ? rd_data.size   : '0;

endmodule
